/* rtl/core/alkt_pkg.sv */
// ----------------------------------------------------------------------------
// alkt_pkg: shared types and constants of the angle lag and Kalman tracker
// Field widths, fixed-point formats, register indexes, reset values and the
// control group of the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none

package alkt_pkg;

    // Field widths
    localparam int ANGLE_W    = 25;
    localparam int DELTA_W    = 26;
    localparam int KANGLE_W   = 32;
    localparam int KDELTA_W   = 25;
    localparam int GAIN_W     = 31;
    localparam int COV_W      = 32;
    localparam int LAG_COEF_W = 16;
    localparam int NOISE_W    = 31;

    // Fixed-point formats
    localparam int ANGLE_FRAC_BITS = 16;
    localparam int COV_FRAC_BITS   = 30;
    localparam int LAG_FRAC_BITS   = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAG_COEFF         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 2'd3;

    localparam logic                  RST_FILTER_ENABLE     = 1'b1;
    localparam logic [LAG_COEF_W-1:0] RST_LAG_COEFF         = 16'd63388;
    localparam logic [NOISE_W-1:0]    RST_PROCESS_NOISE     = 31'd10737;
    localparam logic [NOISE_W-1:0]    RST_MEASUREMENT_NOISE = 31'd10737418;

    // Covariance arithmetic widths
    localparam int PM_W  = COV_W + 1;   // P + Q
    localparam int DEN_W = COV_W + 2;   // P + Q + R

    localparam logic [GAIN_W-1:0] COV_ONE = 31'd1073741824;

    // Half and full turn in Q9.16, at delta width
    localparam logic signed [DELTA_W-1:0] HALF_TURN = 26'sd11796480;
    localparam logic signed [DELTA_W-1:0] FULL_TURN = 26'sd23592960;

    // Shared multiplier: 18 x 34 signed, 65-bit accumulator
    localparam int MAC_A_W   = 18;
    localparam int MAC_B_W   = 34;
    localparam int MAC_P_W   = MAC_A_W + MAC_B_W;
    localparam int MAC_ACC_W = 65;
    localparam int MAC_SHIFT = 16;

    typedef struct packed {
        logic mul_en;   // load the product register
        logic acc_en;   // add the product into the accumulator
        logic clr;      // start a new sum
        logic sh16;     // weight the product by 2^16
    } t_mac_ctl;

    // Fold an angle into [-180, +180]; one step covers the input range
    function automatic logic signed [ANGLE_W-1:0] wrap_angle(
        input logic signed [DELTA_W-1:0] a
    );
        logic signed [DELTA_W-1:0] r;
        begin
            r = a;
            if (a > HALF_TURN) begin
                r = a - FULL_TURN;
            end else if (a < -HALF_TURN) begin
                r = a + FULL_TURN;
            end
            return r[ANGLE_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/core/alkt_div.sv */
// ----------------------------------------------------------------------------
// alkt_div: iterative gain divider
// Restoring division of num * 2^30 by den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module alkt_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [alkt_pkg::PM_W-1:0]  i_num,
    input  wire logic [alkt_pkg::DEN_W-1:0] i_den,
    output logic                            o_done,
    output logic [alkt_pkg::GAIN_W-1:0]     o_quot
);

    localparam int STEPS = alkt_pkg::GAIN_W;
    localparam int CNT_W = $clog2(STEPS);
    localparam int REM_W = alkt_pkg::DEN_W + 1;
    localparam int QW    = alkt_pkg::GAIN_W;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [REM_W-1:0] r_rem;
    logic [alkt_pkg::DEN_W-1:0] r_den;
    logic [QW-1:0]    r_quot;

    logic             ge;
    logic [REM_W-1:0] rem_sub;

    always_comb begin
        ge      = r_rem >= REM_W'(r_den);
        rem_sub = ge ? (r_rem - REM_W'(r_den)) : r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= REM_W'(i_num);
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_quot <= {r_quot[QW-2:0], ge};
            r_rem  <= {rem_sub[REM_W-2:0], 1'b0};
        end
    end

    // zero denominator gives no gain
    always_comb begin
        if (r_den == '0) begin
            o_quot = '0;
        end else if (r_quot > alkt_pkg::COV_ONE) begin
            o_quot = alkt_pkg::COV_ONE;
        end else begin
            o_quot = r_quot;
        end
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

/* rtl/core/alkt_mac.sv */
// ----------------------------------------------------------------------------
// alkt_mac: shared multiply-accumulate unit
// Registered 18 x 34 signed product, then a 65-bit accumulator with an
// optional 2^16 weight on the addend.
// ----------------------------------------------------------------------------
`default_nettype none

module alkt_mac (
    input  wire logic                                 i_clk,
    input  wire alkt_pkg::t_mac_ctl                   i_ctl,
    input  wire logic signed [alkt_pkg::MAC_A_W-1:0]  i_a,
    input  wire logic signed [alkt_pkg::MAC_B_W-1:0]  i_b,
    output logic signed [alkt_pkg::MAC_ACC_W-1:0]     o_acc
);

    localparam int PW = alkt_pkg::MAC_P_W;
    localparam int AW = alkt_pkg::MAC_ACC_W;

    logic signed [PW-1:0] r_prod;
    logic signed [AW-1:0] r_acc;
    logic signed [AW-1:0] prod_ext;
    logic signed [AW-1:0] addend;
    logic signed [AW-1:0] base;

    always_comb begin
        prod_ext = AW'(r_prod);
        addend   = i_ctl.sh16 ? (prod_ext <<< alkt_pkg::MAC_SHIFT) : prod_ext;
        base     = i_ctl.clr ? '0 : r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_a * i_b;
        end
        if (i_ctl.acc_en) begin
            r_acc <= base + addend;
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

/* rtl/core/angle_lag_and_kalman_tracker_unit.sv */
// ----------------------------------------------------------------------------
// angle_lag_and_kalman_tracker_unit: angle tracker with lag and Kalman filter
// Integrates a per-tick velocity into a wrapped angle, runs a first-order lag
// on it and a scalar Kalman filter on the velocity with a saturating sum.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: one request per tick (velocity, override flag and angle),
//   taken when i_valid is high and o_stall is low. Output channel: one result
//   per enabled tick on o_valid / i_stall, held in an output register.
//   Configuration: i_cfg_we writes i_cfg_index with i_cfg_data at once; write
//   only while the block is idle.
//   Timing: an enabled request runs through a set-up step, the bit-serial
//   gain divider and a hand-over step, then the shared multiplier (six
//   partial products, pipelined into one accumulator), then commit. A
//   disabled request only applies the override.
//   o_stall stays high while a request is at work.
//   Stall: the output register holds a finished result while i_stall is high;
//   the next request is still taken, and its commit waits for a free output.
//   Reset: i_rst_n, synchronous and active low, restores the register reset
//   values, clears angle, lag, estimate and sum, sets covariance to 1.0 and
//   drops any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module angle_lag_and_kalman_tracker_unit (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // configuration
    input  wire logic                                   i_cfg_we,
    input  wire logic [alkt_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [alkt_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // request channel
    input  wire logic                                   i_valid,
    output logic                                        o_stall,
    input  wire logic signed [alkt_pkg::ANGLE_W-1:0]    i_velocity_measurement,
    input  wire logic                                   i_override_enable,
    input  wire logic signed [alkt_pkg::ANGLE_W-1:0]    i_override_angle,
    // result channel
    output logic                                        o_valid,
    input  wire logic                                   i_stall,
    output logic signed [alkt_pkg::ANGLE_W-1:0]         o_angle,
    output logic signed [alkt_pkg::DELTA_W-1:0]         o_angle_delta,
    output logic signed [alkt_pkg::ANGLE_W-1:0]         o_lag_angle,
    output logic signed [alkt_pkg::DELTA_W-1:0]         o_lag_delta,
    output logic signed [alkt_pkg::KANGLE_W-1:0]        o_kalman_angle,
    output logic signed [alkt_pkg::KDELTA_W-1:0]        o_kalman_delta,
    output logic [alkt_pkg::GAIN_W-1:0]                 o_kalman_gain
);

    localparam int AW   = alkt_pkg::ANGLE_W;
    localparam int DW   = alkt_pkg::DELTA_W;
    localparam int KW   = alkt_pkg::KANGLE_W;
    localparam int KDW  = alkt_pkg::KDELTA_W;
    localparam int GW   = alkt_pkg::GAIN_W;
    localparam int CW   = alkt_pkg::COV_W;
    localparam int LCW  = alkt_pkg::LAG_COEF_W;
    localparam int NW   = alkt_pkg::NOISE_W;
    localparam int PMW  = alkt_pkg::PM_W;
    localparam int DENW = alkt_pkg::DEN_W;
    localparam int MAW  = alkt_pkg::MAC_A_W;
    localparam int MBW  = alkt_pkg::MAC_B_W;
    localparam int ACW  = alkt_pkg::MAC_ACC_W;
    localparam int SUMW = KW + 1;
    localparam int HW   = alkt_pkg::MAC_SHIFT;

    // sequencer codes
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_MUL  = 2'd3;

    localparam logic [2:0] STEP_LAG  = 3'd3;   // lag sum ready in accumulator
    localparam logic [2:0] STEP_CORR = 3'd5;   // correction sum ready
    localparam logic [2:0] STEP_LAST = 3'd7;   // covariance sum ready, commit

    localparam logic signed [SUMW-1:0] KSUM_MAX = 33'sh0_7FFF_FFFF;
    localparam logic signed [SUMW-1:0] KSUM_MIN = -33'sh0_8000_0000;

    // half-away-from-zero rounding shift
    function automatic logic signed [ACW-1:0] round_shift(
        input logic signed [ACW-1:0] v,
        input int unsigned           s
    );
        logic [ACW-1:0] mag;
        logic [ACW-1:0] res;
        begin
            mag = v[ACW-1] ? -v : v;
            mag = (mag + (ACW'(1) << (s - 1))) >> s;
            res = v[ACW-1] ? -mag : mag;
            return res;
        end
    endfunction

    // configuration registers
    logic            r_filter_en;
    logic [LCW-1:0]  r_lag_coeff;
    logic [NW-1:0]   r_q_noise;
    logic [NW-1:0]   r_r_noise;

    // filter state
    logic signed [AW-1:0] r_tracked;
    logic signed [AW-1:0] r_lag;
    logic signed [AW-1:0] r_xhat;
    logic [CW-1:0]        r_cov;
    logic signed [KW-1:0] r_int;
    logic signed [AW-1:0] r_prev;

    // working registers
    logic [1:0]            r_state;
    logic [2:0]            r_cnt;
    logic signed [AW-1:0]  r_vel;
    logic signed [AW-1:0]  r_wrap;
    logic                  r_ovr;
    logic signed [AW-1:0]  r_ovr_ang;
    logic signed [DW-1:0]  r_diff;
    logic [PMW-1:0]        r_pm;
    logic [GW-1:0]         r_gain;
    logic signed [AW-1:0]  r_lag_new;

    // output register
    logic                   r_out_valid;
    logic signed [AW-1:0]   r_o_angle;
    logic signed [DW-1:0]   r_o_angle_delta;
    logic signed [AW-1:0]   r_o_lag_angle;
    logic signed [DW-1:0]   r_o_lag_delta;
    logic signed [KW-1:0]   r_o_kalman_angle;
    logic signed [KDW-1:0]  r_o_kalman_delta;
    logic [GW-1:0]          r_o_kalman_gain;

    // combinational helpers
    logic                   in_accept;
    logic                   out_free;
    logic                   commit;
    logic [PMW-1:0]         pm;
    logic [DENW-1:0]        den;
    logic                   div_done;
    logic [GW-1:0]          div_quot;
    logic [LCW:0]           lag_comp;
    logic [GW-1:0]          gain_comp;
    alkt_pkg::t_mac_ctl     mac_ctl;
    logic signed [MAW-1:0]  mac_a;
    logic signed [MBW-1:0]  mac_b;
    logic signed [ACW-1:0]  mac_acc;
    logic signed [ACW-1:0]  lag_round;
    logic signed [ACW-1:0]  corr_round;
    logic [CW+1:0]          p_full;
    logic [CW-1:0]          p_sat;
    logic signed [SUMW-1:0] ksum;
    logic signed [KW-1:0]   int_new;
    logic signed [AW-1:0]   angle_new;

    assign in_accept = i_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_stall;
    assign commit    = (r_state == S_MUL) && (r_cnt == STEP_LAST) && out_free;

    assign pm  = PMW'(r_cov) + PMW'(r_q_noise);
    assign den = DENW'(pm) + DENW'(r_r_noise);

    assign lag_comp  = (LCW + 1)'(1 << alkt_pkg::LAG_FRAC_BITS) - (LCW + 1)'(r_lag_coeff);
    assign gain_comp = alkt_pkg::COV_ONE - r_gain;

    // gain divider, started from the set-up cycle
    alkt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_PREP),
        .i_num   (pm),
        .i_den   (den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // multiplier schedule: product k issues on step k and passes through the product register into the sum
    always_comb begin
        mac_ctl.mul_en = (r_state == S_MUL) && (r_cnt <= 3'd5);
        mac_ctl.acc_en = (r_state == S_MUL) && (r_cnt >= 3'd1) && (r_cnt <= 3'd6);
        mac_ctl.clr    = r_cnt inside {3'd1, 3'd3, 3'd5};
        mac_ctl.sh16   = r_cnt inside {3'd4, 3'd6};
        case (r_cnt)
            3'd0: begin
                mac_a = MAW'(r_lag_coeff);
                mac_b = MBW'(r_lag);
            end
            3'd1: begin
                mac_a = MAW'(lag_comp);
                mac_b = MBW'(r_wrap);
            end
            3'd2: begin
                mac_a = MAW'(r_gain[HW-1:0]);
                mac_b = MBW'(r_diff);
            end
            3'd3: begin
                mac_a = MAW'(r_gain[GW-1:HW]);
                mac_b = MBW'(r_diff);
            end
            3'd4: begin
                mac_a = MAW'(gain_comp[HW-1:0]);
                mac_b = MBW'(r_pm);
            end
            3'd5: begin
                mac_a = MAW'(gain_comp[GW-1:HW]);
                mac_b = MBW'(r_pm);
            end
            default: begin
                mac_a = '0;
                mac_b = '0;
            end
        endcase
    end

    alkt_mac u_mac (
        .i_clk (i_clk),
        .i_ctl (mac_ctl),
        .i_a   (mac_a),
        .i_b   (mac_b),
        .o_acc (mac_acc)
    );

    // finishing arithmetic on the accumulator
    always_comb begin
        lag_round  = round_shift(mac_acc, alkt_pkg::LAG_FRAC_BITS);
        corr_round = round_shift(mac_acc, alkt_pkg::COV_FRAC_BITS);
        p_full     = mac_acc[alkt_pkg::COV_FRAC_BITS +: CW + 2];
        p_sat      = (p_full[CW+1:CW] != 2'b00) ? '1 : p_full[CW-1:0];
        ksum       = SUMW'(r_int) + SUMW'(r_xhat);
        if (ksum > KSUM_MAX) begin
            int_new = KSUM_MAX[KW-1:0];
        end else if (ksum < KSUM_MIN) begin
            int_new = KSUM_MIN[KW-1:0];
        end else begin
            int_new = ksum[KW-1:0];
        end
        angle_new  = r_ovr ? r_ovr_ang : r_wrap;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_en <= alkt_pkg::RST_FILTER_ENABLE;
            r_lag_coeff <= alkt_pkg::RST_LAG_COEFF;
            r_q_noise   <= alkt_pkg::RST_PROCESS_NOISE;
            r_r_noise   <= alkt_pkg::RST_MEASUREMENT_NOISE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                alkt_pkg::REG_FILTER_ENABLE:     r_filter_en <= i_cfg_data[0];
                alkt_pkg::REG_LAG_COEFF:         r_lag_coeff <= i_cfg_data[LCW-1:0];
                alkt_pkg::REG_PROCESS_NOISE:     r_q_noise   <= i_cfg_data[NW-1:0];
                alkt_pkg::REG_MEASUREMENT_NOISE: r_r_noise   <= i_cfg_data[NW-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_tracked <= '0;
            r_lag     <= '0;
            r_xhat    <= '0;
            r_cov     <= CW'(alkt_pkg::COV_ONE);
            r_int     <= '0;
            r_prev    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        if (r_filter_en) begin
                            r_state <= S_PREP;
                        end else if (i_override_enable) begin
                            // disabled tick: apply the override only
                            r_tracked <= alkt_pkg::wrap_angle(DW'(i_override_angle));
                        end
                    end
                end
                S_PREP: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_MUL;
                        r_cnt   <= '0;
                    end
                end
                S_MUL: begin
                    if (r_cnt != STEP_LAST) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (r_cnt == STEP_CORR) begin
                        r_xhat <= AW'(DW'(r_xhat) + corr_round[DW-1:0]);
                    end
                    if (commit) begin
                        r_tracked <= angle_new;
                        r_lag     <= r_lag_new;
                        r_cov     <= p_sat;
                        r_int     <= int_new;
                        r_prev    <= angle_new;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // working payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_vel     <= i_velocity_measurement;
            r_wrap    <= alkt_pkg::wrap_angle(DW'(r_tracked) + DW'(i_velocity_measurement));
            r_ovr     <= i_override_enable;
            r_ovr_ang <= alkt_pkg::wrap_angle(DW'(i_override_angle));
        end
        if (r_state == S_PREP) begin
            r_pm   <= pm;
            r_diff <= DW'(r_vel) - DW'(r_xhat);
        end
        if ((r_state == S_DIV) && div_done) begin
            r_gain <= div_quot;
        end
        if ((r_state == S_MUL) && (r_cnt == STEP_LAG)) begin
            r_lag_new <= lag_round[AW-1:0];
        end
    end

    // output register: hold while stalled, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_o_angle        <= angle_new;
            r_o_angle_delta  <= DW'(angle_new) - DW'(r_prev);
            r_o_lag_angle    <= r_lag_new;
            r_o_lag_delta    <= DW'(r_lag_new) - DW'(r_lag);
            r_o_kalman_angle <= int_new;
            r_o_kalman_delta <= KDW'(SUMW'(int_new) - SUMW'(r_int));
            r_o_kalman_gain  <= r_gain;
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_angle        = r_o_angle;
    assign o_angle_delta  = r_o_angle_delta;
    assign o_lag_angle    = r_o_lag_angle;
    assign o_lag_delta    = r_o_lag_delta;
    assign o_kalman_angle = r_o_kalman_angle;
    assign o_kalman_delta = r_o_kalman_delta;
    assign o_kalman_gain  = r_o_kalman_gain;

endmodule

`default_nettype wire

/* rtl/core/alkt_checker.sv */
// ----------------------------------------------------------------------------
// alkt_checker: port-level assertions for the tracker
// Watches reset, result hold under stall, result ranges and result timing.
// ----------------------------------------------------------------------------
`default_nettype none

module alkt_checker (
    input wire logic                                  i_clk,
    input wire logic                                  i_rst_n,
    input wire logic                                  o_stall,
    input wire logic                                  o_valid,
    input wire logic                                  i_stall,
    input wire logic signed [alkt_pkg::ANGLE_W-1:0]   o_angle,
    input wire logic signed [alkt_pkg::KANGLE_W-1:0]  o_kalman_angle,
    input wire logic [alkt_pkg::GAIN_W-1:0]           o_kalman_gain
);

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_angle) && $stable(o_kalman_angle))
        else $error("stalled result changed");

    // gain never exceeds one
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_kalman_gain <= alkt_pkg::COV_ONE)
        else $error("gain above one");

    // reported angle stays wrapped
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_angle <= alkt_pkg::HALF_TURN) && (o_angle >= -alkt_pkg::HALF_TURN))
        else $error("angle outside half turn");

    // a fresh result only comes out of a request at work
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without a request at work");

endmodule

bind angle_lag_and_kalman_tracker_unit alkt_checker u_alkt_checker (.*);

`default_nettype wire

/* sim/tb_angle_lag_and_kalman_tracker_unit.sv */
// ----------------------------------------------------------------------------
// tb_angle_lag_and_kalman_tracker_unit: self-checking bench of the angle tracker
// Drives tick requests through the valid/stall channel, rewrites the filter
// registers between phases, and checks every result against an in-bench
// prediction of angle wrap, lag filter, Kalman gain and saturating sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_angle_lag_and_kalman_tracker_unit;

    typedef longint unsigned t_u64;

    // Settle time before touching registers
    localparam int BLOCK_LATENCY = 42;
    localparam int SETTLE_CYCLES = BLOCK_LATENCY + 8;
    localparam t_u64 UNITY_Q30   = 64'd1 << alkt_pkg::COV_FRAC_BITS;
    localparam int ANGLE_MAX     = 11796480;    // +180 degrees in Q9.16
    localparam int RANDOM_PHASES = 14;
    localparam int TICKS_ON      = 108;         // requests per enabled phase
    localparam int TICKS_OFF     = 40;          // requests in the disabled phase

    typedef struct packed {
        logic signed [alkt_pkg::ANGLE_W-1:0]  angle;
        logic signed [alkt_pkg::DELTA_W-1:0]  angle_delta;
        logic signed [alkt_pkg::ANGLE_W-1:0]  lag_angle;
        logic signed [alkt_pkg::DELTA_W-1:0]  lag_delta;
        logic signed [alkt_pkg::KANGLE_W-1:0] kalman_angle;
        logic signed [alkt_pkg::KDELTA_W-1:0] kalman_delta;
        logic [alkt_pkg::GAIN_W-1:0]          kalman_gain;
    } t_reading;

    typedef enum logic {ROW_TICK, ROW_WRITE} t_row_kind;

    typedef struct {
        t_row_kind                           kind;
        logic signed [alkt_pkg::ANGLE_W-1:0] vel;
        logic                                ovr;
        logic signed [alkt_pkg::ANGLE_W-1:0] ovr_angle;
        bit                                  typed;   // angle and angle_delta given by hand
        int                                  want_angle;
        int                                  want_delta;
        logic [alkt_pkg::CFG_IDX_W-1:0]      reg_index;
        logic [alkt_pkg::CFG_DATA_W-1:0]     reg_data;
    } t_stim_row;

    // DUT ports
    logic                                  i_clk;
    logic                                  i_rst_n;
    logic                                  i_cfg_we;
    logic [alkt_pkg::CFG_IDX_W-1:0]        i_cfg_index;
    logic [alkt_pkg::CFG_DATA_W-1:0]       i_cfg_data;
    logic                                  i_valid;
    logic                                  o_stall;
    logic signed [alkt_pkg::ANGLE_W-1:0]   i_velocity_measurement;
    logic                                  i_override_enable;
    logic signed [alkt_pkg::ANGLE_W-1:0]   i_override_angle;
    logic                                  o_valid;
    logic                                  i_stall;
    logic signed [alkt_pkg::ANGLE_W-1:0]   o_angle;
    logic signed [alkt_pkg::DELTA_W-1:0]   o_angle_delta;
    logic signed [alkt_pkg::ANGLE_W-1:0]   o_lag_angle;
    logic signed [alkt_pkg::DELTA_W-1:0]   o_lag_delta;
    logic signed [alkt_pkg::KANGLE_W-1:0]  o_kalman_angle;
    logic signed [alkt_pkg::KDELTA_W-1:0]  o_kalman_delta;
    logic [alkt_pkg::GAIN_W-1:0]           o_kalman_gain;

    // Register copies held by the predictor
    bit               cfg_enable;
    bit [15:0]        cfg_lag;
    bit [30:0]        cfg_q;
    bit [30:0]        cfg_r;

    // Predicted filter state
    longint           est_angle;        // stored angle
    longint           est_lag;          // lag-filtered angle
    longint           est_vel;          // Kalman velocity estimate
    t_u64             est_cov;          // error covariance, Q2.30
    longint           est_sum;          // saturating sum of estimates
    longint           last_reported;    // angle of the last emitted result

    t_reading         pending_readings[$];
    t_stim_row        stim_rows[$];

    int               snd_idle_pct;
    int               rcv_idle_pct;
    int               ticks_sent;
    int               ticks_disabled;
    int               readings_checked;
    int               mismatches;

    angle_lag_and_kalman_tracker_unit u_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data),
        .i_valid                (i_valid),
        .o_stall                (o_stall),
        .i_velocity_measurement (i_velocity_measurement),
        .i_override_enable      (i_override_enable),
        .i_override_angle       (i_override_angle),
        .o_valid                (o_valid),
        .i_stall                (i_stall),
        .o_angle                (o_angle),
        .o_angle_delta          (o_angle_delta),
        .o_lag_angle            (o_lag_angle),
        .o_lag_delta            (o_lag_delta),
        .o_kalman_angle         (o_kalman_angle),
        .o_kalman_delta         (o_kalman_delta),
        .o_kalman_gain          (o_kalman_gain)
    );

    // Clock: 12 ns period
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Give up well beyond the slowest legal run
    initial begin
        #12_000_000;
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Fold into [-180, +180]; both ends are kept
    function automatic longint fold_half_turn(longint a);
        while (a > ANGLE_MAX) a -= 2 * ANGLE_MAX;
        while (a < -ANGLE_MAX) a += 2 * ANGLE_MAX;
        return a;
    endfunction

    // Arithmetic shift right, rounding half away from zero
    function automatic longint round_shift(longint v, int s);
        t_u64 half;
        half = 64'd1 << (s - 1);
        if (v >= 0) return longint'((t_u64'(v) + half) >> s);
        return -longint'((t_u64'(-v) + half) >> s);
    endfunction

    function automatic void reset_tracker_model();
        cfg_enable    = alkt_pkg::RST_FILTER_ENABLE;
        cfg_lag       = alkt_pkg::RST_LAG_COEFF;
        cfg_q         = alkt_pkg::RST_PROCESS_NOISE;
        cfg_r         = alkt_pkg::RST_MEASUREMENT_NOISE;
        est_angle     = 0;
        est_lag       = 0;
        est_vel       = 0;
        est_cov       = UNITY_Q30;
        est_sum       = 0;
        last_reported = 0;
    endfunction

    // Advance the model by one tick; return 1 when the tick yields a result
    function automatic bit track_tick(
        input  logic signed [alkt_pkg::ANGLE_W-1:0] vel_in,
        input  logic                                ovr,
        input  logic signed [alkt_pkg::ANGLE_W-1:0] ovr_in,
        output t_reading                            rd
    );
        longint vel;
        longint ovr_angle;
        longint prior_lag;
        longint prior_sum;
        longint corr;
        longint diff;
        t_u64   pm;
        t_u64   den;
        t_u64   gain;
        t_u64   p;
        vel       = vel_in;
        ovr_angle = fold_half_turn(longint'(ovr_in));
        rd        = '0;

        // Disabled tick: override only, nothing reported
        if (!cfg_enable) begin
            if (ovr) est_angle = ovr_angle;
            return 1'b0;
        end

        est_angle = fold_half_turn(est_angle + vel);

        prior_lag = est_lag;
        est_lag   = round_shift(longint'(cfg_lag) * est_lag +
                                (65536 - longint'(cfg_lag)) * est_angle,
                                alkt_pkg::LAG_FRAC_BITS);

        // Kalman update on the velocity; an empty denominator gives no gain
        pm   = est_cov + t_u64'(cfg_q);
        den  = pm + t_u64'(cfg_r);
        gain = (den == 0) ? 64'd0 : (pm << alkt_pkg::COV_FRAC_BITS) / den;
        if (gain > UNITY_Q30) gain = UNITY_Q30;
        corr    = round_shift(longint'(gain) * (vel - est_vel), alkt_pkg::COV_FRAC_BITS);
        est_vel = est_vel + corr;
        p       = ((UNITY_Q30 - gain) * pm) >> alkt_pkg::COV_FRAC_BITS;
        est_cov = (p > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : p;

        prior_sum = est_sum;
        est_sum   = est_sum + est_vel;
        if (est_sum > 64'sd2147483647) est_sum = 64'sd2147483647;
        if (est_sum < -64'sd2147483648) est_sum = -64'sd2147483648;

        if (ovr) est_angle = ovr_angle;

        rd.angle        = est_angle[alkt_pkg::ANGLE_W-1:0];
        diff            = est_angle - last_reported;
        rd.angle_delta  = diff[alkt_pkg::DELTA_W-1:0];
        rd.lag_angle    = est_lag[alkt_pkg::ANGLE_W-1:0];
        diff            = est_lag - prior_lag;
        rd.lag_delta    = diff[alkt_pkg::DELTA_W-1:0];
        rd.kalman_angle = est_sum[alkt_pkg::KANGLE_W-1:0];
        diff            = est_sum - prior_sum;
        rd.kalman_delta = diff[alkt_pkg::KDELTA_W-1:0];
        rd.kalman_gain  = gain[alkt_pkg::GAIN_W-1:0];

        last_reported = est_angle;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic void add_tick(int vel, bit ovr, int ovr_angle,
                                     bit typed = 1'b0, int want_angle = 0,
                                     int want_delta = 0);
        t_stim_row r;
        r            = '{kind: ROW_TICK, default: '0};
        r.vel        = vel[alkt_pkg::ANGLE_W-1:0];
        r.ovr        = ovr;
        r.ovr_angle  = ovr_angle[alkt_pkg::ANGLE_W-1:0];
        r.typed      = typed;
        r.want_angle = want_angle;
        r.want_delta = want_delta;
        stim_rows.push_back(r);
    endfunction

    function automatic void add_write(logic [alkt_pkg::CFG_IDX_W-1:0] idx, int data);
        t_stim_row r;
        r           = '{kind: ROW_WRITE, default: '0};
        r.reg_index = idx;
        r.reg_data  = data[alkt_pkg::CFG_DATA_W-1:0];
        stim_rows.push_back(r);
    endfunction

    // Drop valid and hold off until every result is in and the block is quiet
    task automatic settle_block();
        i_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic [alkt_pkg::CFG_IDX_W-1:0] idx, int data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data[alkt_pkg::CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            alkt_pkg::REG_FILTER_ENABLE:     cfg_enable = data[0];
            alkt_pkg::REG_LAG_COEFF:         cfg_lag    = data[15:0];
            alkt_pkg::REG_PROCESS_NOISE:     cfg_q      = data[30:0];
            alkt_pkg::REG_MEASUREMENT_NOISE: cfg_r      = data[30:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Offer one tick request, hold it until taken, then log its prediction
    task automatic send_tick(t_stim_row r);
        t_reading rd;
        if ($urandom_range(0, 99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < snd_idle_pct);
        end
        i_valid                <= 1'b1;
        i_velocity_measurement <= r.vel;
        i_override_enable      <= r.ovr;
        i_override_angle       <= r.ovr_angle;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        ticks_sent++;
        if (track_tick(r.vel, r.ovr, r.ovr_angle, rd)) begin
            // Hand-typed rows replace the angle pair of the expectation
            if (r.typed) begin
                rd.angle       = r.want_angle[alkt_pkg::ANGLE_W-1:0];
                rd.angle_delta = r.want_delta[alkt_pkg::DELTA_W-1:0];
            end
            pending_readings.push_back(rd);
        end else begin
            ticks_disabled++;
        end
    endtask

    function automatic t_stim_row random_tick();
        t_stim_row r;
        int        t;
        r = '{kind: ROW_TICK, default: '0};
        // Mostly modest turns, some across the whole range, a few raw 25-bit
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: t = int'($urandom_range(0, 1000000)) - 500000;
            6, 7, 8:          t = int'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX;
            default:          t = int'($urandom());
        endcase
        r.vel = t[alkt_pkg::ANGLE_W-1:0];
        r.ovr = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 9) != 0)
            t = int'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX;
        else
            t = int'($urandom());
        r.ovr_angle = t[alkt_pkg::ANGLE_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stall, compare each accepted result in order
    // ------------------------------------------------------------------------
    initial begin
        t_reading got;
        t_reading want;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
                got = {o_angle, o_angle_delta, o_lag_angle, o_lag_delta,
                       o_kalman_angle, o_kalman_delta, o_kalman_gain};
                if (pending_readings.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] unexpected result: angle=%0d kalman=%0d",
                                 $realtime, got.angle, got.kalman_angle);
                end else begin
                    want = pending_readings.pop_front();
                    readings_checked++;
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("[%0t] mismatch on result %0d", $realtime,
                                     readings_checked);
                            $display("  angle  %0d/%0d  delta  %0d/%0d (expected/actual)",
                                     want.angle, got.angle, want.angle_delta,
                                     got.angle_delta);
                            $display("  lag    %0d/%0d  delta  %0d/%0d",
                                     want.lag_angle, got.lag_angle, want.lag_delta,
                                     got.lag_delta);
                            $display("  kalman %0d/%0d  delta  %0d/%0d  gain %0d/%0d",
                                     want.kalman_angle, got.kalman_angle,
                                     want.kalman_delta, got.kalman_delta,
                                     want.kalman_gain, got.kalman_gain);
                        end
                    end
                end
            end
            i_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Request side: reset, directed rows, random phases, drain, verdict
    // ------------------------------------------------------------------------
    initial begin
        t_stim_row r;
        int        n_ticks;
        i_rst_n                <= 1'b0;
        i_cfg_we               <= 1'b0;
        i_cfg_index            <= alkt_pkg::REG_FILTER_ENABLE;
        i_cfg_data             <= '0;
        i_valid                <= 1'b0;
        i_velocity_measurement <= '0;
        i_override_enable      <= 1'b0;
        i_override_angle       <= '0;
        snd_idle_pct           = 36;
        rcv_idle_pct           = 65;
        ticks_sent             = 0;
        ticks_disabled         = 0;
        readings_checked       = 0;
        mismatches             = 0;
        reset_tracker_model();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Wrap at both ends: exactly +/-180 holds, one LSB past folds over
        add_tick(0, 1'b0, 0, 1'b1, 0, 0);
        add_tick(ANGLE_MAX, 1'b0, 0, 1'b1, ANGLE_MAX, ANGLE_MAX);
        add_tick(1, 1'b0, 0, 1'b1, -ANGLE_MAX + 1, -2 * ANGLE_MAX + 1);
        add_tick(-1, 1'b0, 0, 1'b1, -ANGLE_MAX, -1);
        add_tick(-1, 1'b0, 0, 1'b1, ANGLE_MAX - 1, 2 * ANGLE_MAX - 1);
        // Velocity beyond the range: full 25-bit extremes
        add_tick(16777215, 1'b0, 0, 1'b1, 4980734, -6815745);
        add_tick(-16777216, 1'b0, 0, 1'b1, 11796478, 6815744);
        // Override at -180 and with out-of-range angles that must be folded
        add_tick(0, 1'b1, -ANGLE_MAX, 1'b1, -ANGLE_MAX, -23592958);
        add_tick(0, 1'b1, 16777215, 1'b1, -6815745, 4980735);
        add_tick(0, 1'b1, -16777216, 1'b1, 6815744, 13631489);
        // Lag coefficient extremes: straight through, then nearly frozen
        add_write(alkt_pkg::REG_LAG_COEFF, 0);
        add_tick(1000000, 1'b0, 0);
        add_tick(-1000000, 1'b1, ANGLE_MAX);
        add_write(alkt_pkg::REG_LAG_COEFF, 65535);
        add_tick(5000000, 1'b0, 0);
        add_tick(-7000000, 1'b0, 0);
        // No noise at all: full gain once, then an empty gain denominator
        add_write(alkt_pkg::REG_PROCESS_NOISE, 0);
        add_write(alkt_pkg::REG_MEASUREMENT_NOISE, 0);
        add_tick(65536, 1'b0, 0);
        add_tick(-65536, 1'b0, 0);
        // Large noise: both set to 2^30 (1.0 at 30 fraction bits)
        add_write(alkt_pkg::REG_PROCESS_NOISE, 1 << 30);
        add_write(alkt_pkg::REG_MEASUREMENT_NOISE, 1 << 30);
        add_tick(3000000, 1'b0, 0);
        add_tick(-3000000, 1'b0, 0);
        // Disabled ticks: only overrides land, no results
        add_write(alkt_pkg::REG_FILTER_ENABLE, 0);
        add_tick(2000000, 1'b1, 5000000);
        add_tick(9000000, 1'b0, 0);
        add_tick(0, 1'b1, -ANGLE_MAX);
        // Back on: delta is measured from the last reported angle
        add_write(alkt_pkg::REG_FILTER_ENABLE, 1);
        add_write(alkt_pkg::REG_PROCESS_NOISE, int'(alkt_pkg::RST_PROCESS_NOISE));
        add_write(alkt_pkg::REG_MEASUREMENT_NOISE, 1);
        add_write(alkt_pkg::REG_LAG_COEFF, int'(alkt_pkg::RST_LAG_COEFF));
        add_tick(100, 1'b0, 0);
        add_tick(-100, 1'b0, 0);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_WRITE) begin
                settle_block();
                write_register(stim_rows[i].reg_index, int'(stim_rows[i].reg_data));
            end else begin
                send_tick(stim_rows[i]);
            end
        end

        // Random phases, each under fresh register settings
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            // Receiver-heavy idling first, then sender-heavy, then none
            if (ph < 5) begin
                snd_idle_pct = 36;
                rcv_idle_pct = 65;
            end else if (ph < 10) begin
                snd_idle_pct = 65;
                rcv_idle_pct = 36;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end

            settle_block();
            write_register(alkt_pkg::REG_FILTER_ENABLE, (ph == 6) ? 0 : 1);
            case ($urandom_range(0, 3))
                0:       write_register(alkt_pkg::REG_LAG_COEFF, 0);
                1:       write_register(alkt_pkg::REG_LAG_COEFF, 65535);
                2:       write_register(alkt_pkg::REG_LAG_COEFF,
                                        int'(alkt_pkg::RST_LAG_COEFF));
                default: write_register(alkt_pkg::REG_LAG_COEFF,
                                        int'($urandom_range(0, 65535)));
            endcase
            case ($urandom_range(0, 4))
                0:       write_register(alkt_pkg::REG_PROCESS_NOISE, 0);
                1:       write_register(alkt_pkg::REG_PROCESS_NOISE, 1 << 30);
                2:       write_register(alkt_pkg::REG_PROCESS_NOISE,
                                        int'(alkt_pkg::RST_PROCESS_NOISE));
                3:       write_register(alkt_pkg::REG_PROCESS_NOISE,
                                        int'($urandom_range(0, 1 << 20)));
                default: write_register(alkt_pkg::REG_PROCESS_NOISE,
                                        int'($urandom_range(0, 1 << 30)));
            endcase
            case ($urandom_range(0, 3))
                0:       write_register(alkt_pkg::REG_MEASUREMENT_NOISE, 1);
                1:       write_register(alkt_pkg::REG_MEASUREMENT_NOISE, 1 << 30);
                2:       write_register(alkt_pkg::REG_MEASUREMENT_NOISE,
                                        int'(alkt_pkg::RST_MEASUREMENT_NOISE));
                default: write_register(alkt_pkg::REG_MEASUREMENT_NOISE,
                                        int'($urandom_range(1, 1 << 30)));
            endcase

            n_ticks = (ph == 6) ? TICKS_OFF : TICKS_ON;
            for (int n = 0; n < n_ticks; n++) begin
                // Hold off mid-phase until the output side has caught up
                if (n == n_ticks / 2) settle_block();
                r = random_tick();
                send_tick(r);
            end
        end

        // Drain: let the last results out, then watch for strays
        settle_block();

        $display("Sent %0d tick requests (%0d with the filter off), checked %0d results",
                 ticks_sent, ticks_disabled, readings_checked);
        $display("Covered wrap and override extremes, lag and noise register limits, "
                 , "an empty gain denominator and three idling patterns");
        if (mismatches == 0 && pending_readings.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
